>>> rtl/psrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psrs_pkg;

    localparam int SlotW     = 8;
    localparam int TimeSlots = 256;
    localparam int SampleW   = 32;
    localparam int FracW     = 16;
    localparam int AccW      = 64;
    localparam int CntW      = 32;
    localparam int KindW     = 3;
    localparam int HalfW     = AccW / 2;
    localparam int ProdW     = 2 * AccW;
    localparam int DivSteps  = AccW / 2;
    localparam int DivCntW   = $clog2(DivSteps);
    localparam int RootW     = 48;
    localparam int SqrtSteps = RootW / 2;
    localparam int SqrtCntW  = $clog2(SqrtSteps);

    localparam logic [1:0] MODE_ACC   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [KindW-1:0] KIND_MIN   = 3'd0;
    localparam logic [KindW-1:0] KIND_MAX   = 3'd1;
    localparam logic [KindW-1:0] KIND_MEAN  = 3'd2;
    localparam logic [KindW-1:0] KIND_SUM   = 3'd3;
    localparam logic [KindW-1:0] KIND_COUNT = 3'd4;
    localparam logic [KindW-1:0] KIND_PROD  = 3'd5;
    localparam logic [KindW-1:0] KIND_VAR   = 3'd6;
    localparam logic [KindW-1:0] KIND_SD    = 3'd7;

    typedef struct packed {
        logic [1:0]                mode;
        logic [SlotW-1:0]          slot;
        logic signed [SampleW-1:0] sample_value;
        logic                      sample_valid;
    } t_in_item;

    typedef struct packed {
        logic [SlotW-1:0]       result_slot;
        logic signed [AccW-1:0] result_value;
        logic                   result_empty;
        logic                   result_saturated;
    } t_out_item;

    typedef struct packed {
        logic [AccW-1:0] acc;
        logic [CntW-1:0] cnt;
        logic [AccW-1:0] mean;
        logic            sat;
    } t_entry;

    typedef struct packed {
        logic load;
        logic dec;
        logic div_step;
        logic div_end;
        logic mul_step;
        logic rnd;
        logic sqrt_step;
        logic sqrt_end;
    } t_cmd;

    typedef struct packed {
        logic dec_div;
        logic dec_mul;
        logic div_last;
        logic divend_mul;
        logic divend_sqrt;
        logic mul_last;
        logic sqrt_last;
    } t_stat;

    // Saturating signed add; the top bit of the result is the overflow flag.
    function automatic logic [AccW:0] f_sat_add(input logic [AccW-1:0] a,
                                                input logic [AccW-1:0] b);
        logic [AccW-1:0] s;
        logic            ovf;
        s   = a + b;
        ovf = (a[AccW-1] == b[AccW-1]) && (s[AccW-1] != a[AccW-1]);
        if (ovf) begin
            s = a[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        end
        return {ovf, s};
    endfunction

    function automatic logic [AccW:0] f_sat_sub(input logic [AccW-1:0] a,
                                                input logic [AccW-1:0] b);
        logic [AccW-1:0] s;
        logic            ovf;
        s   = a - b;
        ovf = (a[AccW-1] != b[AccW-1]) && (s[AccW-1] != a[AccW-1]);
        if (ovf) begin
            s = a[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        end
        return {ovf, s};
    endfunction

    function automatic logic [AccW-1:0] f_mag(input logic [AccW-1:0] x);
        return x[AccW-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [AccW-1:0] f_apply_sign(input logic [AccW-1:0] m,
                                                     input logic neg);
        return neg ? (~m + 1'b1) : m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/psrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module psrs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire psrs_pkg::t_stat i_stat,
    output logic                 o_busy,
    output psrs_pkg::t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DEC    = 8'b0000_0010,
        ST_DIV    = 8'b0000_0100,
        ST_DIVEND = 8'b0000_1000,
        ST_MUL    = 8'b0001_0000,
        ST_RND    = 8'b0010_0000,
        ST_SQRT   = 8'b0100_0000,
        ST_SQEND  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_DEC;
            end
            ST_DEC: begin
                if (i_stat.dec_div)      n_state = ST_DIV;
                else if (i_stat.dec_mul) n_state = ST_MUL;
                else                     n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (i_stat.div_last) n_state = ST_DIVEND;
            end
            ST_DIVEND: begin
                if (i_stat.divend_mul)       n_state = ST_MUL;
                else if (i_stat.divend_sqrt) n_state = ST_SQRT;
                else                         n_state = ST_IDLE;
            end
            ST_MUL: begin
                if (i_stat.mul_last) n_state = ST_RND;
            end
            ST_RND:   n_state = ST_IDLE;
            ST_SQRT: begin
                if (i_stat.sqrt_last) n_state = ST_SQEND;
            end
            ST_SQEND: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_cmd.load      = (r_state == ST_IDLE) && i_start;
    assign o_cmd.dec       = (r_state == ST_DEC);
    assign o_cmd.div_step  = (r_state == ST_DIV);
    assign o_cmd.div_end   = (r_state == ST_DIVEND);
    assign o_cmd.mul_step  = (r_state == ST_MUL);
    assign o_cmd.rnd       = (r_state == ST_RND);
    assign o_cmd.sqrt_step = (r_state == ST_SQRT);
    assign o_cmd.sqrt_end  = (r_state == ST_SQEND);

    a_accept_to_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state == ST_DEC))
        else $error("accepted beat did not enter decode");

    a_mul_to_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && i_stat.mul_last) |=> (r_state == ST_RND))
        else $error("multiplier finish did not lead to rounding");

endmodule
`default_nettype wire

>>> rtl/psrs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module psrs_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire psrs_pkg::t_in_item            i_item,
    input  wire logic [psrs_pkg::KindW-1:0]    i_kind,
    input  wire psrs_pkg::t_cmd                i_cmd,
    output psrs_pkg::t_stat                    o_stat,
    output logic                               o_result_strobe,
    output psrs_pkg::t_out_item                o_result
);

    localparam int AccW  = psrs_pkg::AccW;
    localparam int CntW  = psrs_pkg::CntW;
    localparam int ProdW = psrs_pkg::ProdW;
    localparam int RootW = psrs_pkg::RootW;
    localparam int HalfW = psrs_pkg::HalfW;
    localparam logic [ProdW-1:0] RndHalf = ProdW'((64'd1 << psrs_pkg::FracW) >> 1);
    localparam logic [AccW-1:0]  PosLimit = {1'b0, {(AccW-1){1'b1}}};
    localparam logic [AccW-1:0]  NegLimit = {1'b1, {(AccW-1){1'b0}}};

    // Slot store with one valid bit per entry; an unwritten entry reads as zero.
    psrs_pkg::t_entry r_mem [psrs_pkg::TimeSlots];
    logic [psrs_pkg::TimeSlots-1:0] r_vld;
    psrs_pkg::t_entry r_rd;
    logic             r_rd_vld;
    psrs_pkg::t_in_item r_item;

    logic [AccW-1:0] r_acc, r_mean, r_v, r_delta;
    logic [CntW-1:0] r_cnt;
    logic            r_sat;

    logic [AccW-1:0] r_dnum;
    logic [CntW-1:0] r_dden, r_drem;
    logic            r_dneg;
    logic [psrs_pkg::DivCntW-1:0] r_dcnt;

    logic [AccW-1:0]  r_ma, r_mb;
    logic             r_mneg;
    logic [ProdW-1:0] r_mprod;
    logic [1:0]       r_mstep;

    logic [2*RootW-1:0] r_sx;
    logic [RootW+1:0]   r_srem;
    logic [RootW-1:0]   r_sroot;
    logic [psrs_pkg::SqrtCntW-1:0] r_scnt;

    logic                r_ostb;
    psrs_pkg::t_out_item r_out;

    psrs_pkg::t_entry w_ent;
    logic [AccW-1:0]  w_v;
    logic             w_cnt_full, w_first;
    logic [CntW-1:0]  w_cnt_new;
    logic [AccW:0]    w_add, w_dsub;
    logic             w_is_acc, w_is_read, w_is_clr, w_is_welford;

    assign w_ent      = r_rd_vld ? r_rd : '0;
    assign w_v        = {{(AccW-psrs_pkg::SampleW){r_item.sample_value[psrs_pkg::SampleW-1]}},
                         r_item.sample_value};
    assign w_cnt_full = &w_ent.cnt;
    assign w_first    = (w_ent.cnt == '0);
    assign w_cnt_new  = w_cnt_full ? w_ent.cnt : w_ent.cnt + 1'b1;
    assign w_add      = psrs_pkg::f_sat_add(w_ent.acc, w_v);
    assign w_dsub     = psrs_pkg::f_sat_sub(w_v, w_ent.mean);
    assign w_is_acc   = (r_item.mode == psrs_pkg::MODE_ACC) && r_item.sample_valid;
    assign w_is_read  = (r_item.mode == psrs_pkg::MODE_READ);
    assign w_is_clr   = (r_item.mode == psrs_pkg::MODE_CLEAR);
    assign w_is_welford = (i_kind == psrs_pkg::KIND_VAR) || (i_kind == psrs_pkg::KIND_SD);

    assign o_stat.dec_div = (w_is_acc && w_is_welford)
        || (w_is_read && (((i_kind == psrs_pkg::KIND_MEAN) && !w_first)
                          || (w_is_welford && (w_ent.cnt > CntW'(1)))));
    assign o_stat.dec_mul     = w_is_acc && (i_kind == psrs_pkg::KIND_PROD);
    assign o_stat.div_last    = (r_dcnt == psrs_pkg::DivCntW'(psrs_pkg::DivSteps - 1));
    assign o_stat.divend_mul  = !w_is_read;
    assign o_stat.divend_sqrt = w_is_read && (i_kind == psrs_pkg::KIND_SD);
    assign o_stat.mul_last    = (r_mstep == 2'd3);
    assign o_stat.sqrt_last   = (r_scnt == psrs_pkg::SqrtCntW'(psrs_pkg::SqrtSteps - 1));

    // Divider: rounded quotient of the finished run.
    logic [AccW-1:0] w_q_rnd, w_step;
    logic [AccW:0]   w_madd, w_esub;
    assign w_q_rnd = r_dnum + AccW'(r_drem >= (r_dden - r_drem));
    assign w_step  = psrs_pkg::f_apply_sign(w_q_rnd, r_dneg);
    assign w_madd  = psrs_pkg::f_sat_add(r_mean, w_step);
    assign w_esub  = psrs_pkg::f_sat_sub(r_v, w_madd[AccW-1:0]);

    // Two restoring divide steps per cycle.
    logic [AccW-1:0] n_dnum;
    logic [CntW-1:0] n_drem;
    always_comb begin : p_div
        logic [CntW:0] t;
        n_dnum = r_dnum;
        n_drem = r_drem;
        for (int k = 0; k < 2; k++) begin
            t      = {n_drem, n_dnum[AccW-1]};
            n_dnum = {n_dnum[AccW-2:0], 1'b0};
            if (t >= {1'b0, r_dden}) begin
                n_drem    = CntW'(t - {1'b0, r_dden});
                n_dnum[0] = 1'b1;
            end else begin
                n_drem = t[CntW-1:0];
            end
        end
    end

    // Divider start operands.
    logic [AccW-1:0] w_dnum0;
    logic [CntW-1:0] w_dden0;
    always_comb begin
        if (w_is_read) begin
            w_dnum0 = w_ent.acc;
            w_dden0 = (i_kind == psrs_pkg::KIND_MEAN) ? w_ent.cnt : w_ent.cnt - 1'b1;
        end else begin
            w_dnum0 = w_dsub[AccW-1:0];
            w_dden0 = w_cnt_new;
        end
    end

    // One 32 by 32 partial product per cycle.
    logic [HalfW-1:0] w_ah, w_bh;
    logic [AccW-1:0]  w_pp;
    logic [1:0]       w_pos;
    logic [ProdW-1:0] w_pp_sh;
    assign w_ah    = r_mstep[1] ? r_ma[AccW-1:HalfW] : r_ma[HalfW-1:0];
    assign w_bh    = r_mstep[0] ? r_mb[AccW-1:HalfW] : r_mb[HalfW-1:0];
    assign w_pp    = AccW'(w_ah) * AccW'(w_bh);
    assign w_pos   = {1'b0, r_mstep[1]} + {1'b0, r_mstep[0]};
    assign w_pp_sh = ProdW'(w_pp) << (w_pos * HalfW);

    // Multiplier start operands.
    logic [AccW-1:0] w_ma0, w_mb0;
    assign w_ma0 = i_cmd.div_end ? r_delta : w_ent.acc;
    assign w_mb0 = i_cmd.div_end ? w_esub[AccW-1:0] : w_v;

    // Rounding and saturation of the fixed-point product.
    logic [ProdW-1:0] w_prnd, w_psh;
    logic             w_povf;
    logic [AccW-1:0]  w_pres;
    logic [AccW:0]    w_m2add;
    assign w_prnd  = r_mprod + RndHalf;
    assign w_psh   = w_prnd >> psrs_pkg::FracW;
    assign w_povf  = (|w_psh[ProdW-1:AccW])
                     || (w_psh[AccW-1:0] > (r_mneg ? NegLimit : PosLimit));
    assign w_pres  = w_povf ? (r_mneg ? NegLimit : PosLimit)
                            : psrs_pkg::f_apply_sign(w_psh[AccW-1:0], r_mneg);
    assign w_m2add = psrs_pkg::f_sat_add(r_acc, w_pres);

    // Two square-root digits per cycle.
    logic [2*RootW-1:0] n_sx;
    logic [RootW+1:0]   n_srem;
    logic [RootW-1:0]   n_sroot;
    always_comb begin : p_sqrt
        logic [RootW+3:0] t;
        logic [RootW+3:0] trial;
        n_sx    = r_sx;
        n_srem  = r_srem;
        n_sroot = r_sroot;
        for (int k = 0; k < 2; k++) begin
            t     = {n_srem, n_sx[2*RootW-1 -: 2]};
            trial = {2'b00, n_sroot, 2'b01};
            n_sx  = {n_sx[2*RootW-3:0], 2'b00};
            if (t >= trial) begin
                n_srem  = (RootW+2)'(t - trial);
                n_sroot = {n_sroot[RootW-2:0], 1'b1};
            end else begin
                n_srem  = t[RootW+1:0];
                n_sroot = {n_sroot[RootW-2:0], 1'b0};
            end
        end
    end

    logic [AccW-1:0] w_var_q;
    assign w_var_q = w_step[AccW-1] ? '0 : w_step;

    // Store write-back.
    logic             w_wr_en;
    psrs_pkg::t_entry w_wr_data;
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_data = w_ent;
        if (i_cmd.dec) begin
            if (w_is_clr) begin
                w_wr_en   = 1'b1;
                w_wr_data = '0;
                if (i_kind == psrs_pkg::KIND_PROD) begin
                    w_wr_data.acc = AccW'(64'd1 << psrs_pkg::FracW);
                end
            end else if (w_is_acc && !o_stat.dec_div && !o_stat.dec_mul) begin
                w_wr_en       = 1'b1;
                w_wr_data.cnt = w_cnt_new;
                w_wr_data.sat = w_ent.sat | w_cnt_full;
                case (i_kind)
                    psrs_pkg::KIND_MIN: begin
                        if (w_first || ($signed(w_v) < $signed(w_ent.acc))) w_wr_data.acc = w_v;
                    end
                    psrs_pkg::KIND_MAX: begin
                        if (w_first || ($signed(w_v) > $signed(w_ent.acc))) w_wr_data.acc = w_v;
                    end
                    psrs_pkg::KIND_MEAN, psrs_pkg::KIND_SUM: begin
                        w_wr_data.acc = w_add[AccW-1:0];
                        w_wr_data.sat = w_ent.sat | w_cnt_full | w_add[AccW];
                    end
                    default: ;
                endcase
            end
        end else if (i_cmd.rnd) begin
            w_wr_en        = 1'b1;
            w_wr_data.cnt  = r_cnt;
            w_wr_data.mean = r_mean;
            if (i_kind == psrs_pkg::KIND_PROD) begin
                w_wr_data.acc = w_pres;
                w_wr_data.sat = r_sat | w_povf;
            end else begin
                w_wr_data.acc = w_m2add[AccW-1:0];
                w_wr_data.sat = r_sat | w_povf | w_m2add[AccW];
            end
        end
    end

    // Result beat.
    logic                w_out_en;
    psrs_pkg::t_out_item w_out;
    always_comb begin
        w_out_en                = 1'b0;
        w_out.result_slot       = r_item.slot;
        w_out.result_value      = '0;
        w_out.result_empty      = 1'b0;
        w_out.result_saturated  = r_sat;
        if (i_cmd.dec && w_is_read && !o_stat.dec_div) begin
            w_out_en               = 1'b1;
            w_out.result_saturated = w_ent.sat;
            case (i_kind)
                psrs_pkg::KIND_MIN, psrs_pkg::KIND_MAX: begin
                    if (w_first) w_out.result_empty = 1'b1;
                    else         w_out.result_value = w_ent.acc;
                end
                psrs_pkg::KIND_SUM, psrs_pkg::KIND_PROD: w_out.result_value = w_ent.acc;
                psrs_pkg::KIND_COUNT: w_out.result_value = AccW'(w_ent.cnt) << psrs_pkg::FracW;
                default: w_out.result_empty = 1'b1;
            endcase
        end else if (i_cmd.div_end && w_is_read && (i_kind != psrs_pkg::KIND_SD)) begin
            w_out_en           = 1'b1;
            w_out.result_value = w_step;
        end else if (i_cmd.sqrt_end) begin
            w_out_en           = 1'b1;
            w_out.result_value = AccW'(r_sroot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd     <= r_mem[i_item.slot];
            r_rd_vld <= r_vld[i_item.slot];
            r_item   <= i_item;
        end
        if (w_wr_en) r_mem[r_item.slot] <= w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_ostb  <= 1'b0;
            r_dcnt  <= '0;
            r_mstep <= '0;
            r_scnt  <= '0;
        end else begin
            if (w_wr_en) r_vld[r_item.slot] <= 1'b1;
            r_ostb <= w_out_en;
            if (i_cmd.dec)           r_dcnt <= '0;
            else if (i_cmd.div_step) r_dcnt <= r_dcnt + 1'b1;
            if (i_cmd.dec || i_cmd.div_end) r_mstep <= '0;
            else if (i_cmd.mul_step)         r_mstep <= r_mstep + 1'b1;
            if (i_cmd.div_end)        r_scnt <= '0;
            else if (i_cmd.sqrt_step) r_scnt <= r_scnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) r_out <= w_out;
        if (i_cmd.dec) begin
            r_acc   <= w_ent.acc;
            r_mean  <= w_ent.mean;
            r_v     <= w_v;
            r_delta <= w_dsub[AccW-1:0];
            r_cnt   <= w_cnt_new;
            r_sat   <= w_ent.sat | (w_is_acc & (w_cnt_full | (w_is_welford & w_dsub[AccW])));
            r_dnum  <= psrs_pkg::f_mag(w_dnum0);
            r_dneg  <= w_dnum0[AccW-1];
            r_dden  <= w_dden0;
            r_drem  <= '0;
        end else if (i_cmd.div_step) begin
            r_dnum <= n_dnum;
            r_drem <= n_drem;
        end else if (i_cmd.div_end && !w_is_read) begin
            r_mean <= w_madd[AccW-1:0];
            r_sat  <= r_sat | w_madd[AccW] | w_esub[AccW];
        end
        if (i_cmd.dec || i_cmd.div_end) begin
            r_ma    <= psrs_pkg::f_mag(w_ma0);
            r_mb    <= psrs_pkg::f_mag(w_mb0);
            r_mneg  <= w_ma0[AccW-1] ^ w_mb0[AccW-1];
            r_mprod <= '0;
        end else if (i_cmd.mul_step) begin
            r_mprod <= r_mprod + w_pp_sh;
        end
        if (i_cmd.div_end) begin
            r_sx    <= (2*RootW)'(w_var_q) << psrs_pkg::FracW;
            r_srem  <= '0;
            r_sroot <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sx    <= n_sx;
            r_srem  <= n_srem;
            r_sroot <= n_sroot;
        end
    end

    assign o_result_strobe = r_ostb;
    assign o_result        = r_out;

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ostb |-> $past(i_cmd.dec || i_cmd.div_end || i_cmd.sqrt_end))
        else $error("result strobe without a finishing step");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_drem < r_dden))
        else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

>>> rtl/per_slot_running_statistics_core.sv
// Channel   Handshake               Payload
// input     start / busy            i_item   (psrs_pkg::t_in_item)
// result    o_result_strobe         o_result (psrs_pkg::t_out_item)
// config    i_cfg_we                i_cfg_data (reducer kind)
//
// Min, max, sum, mean and count accumulates, clears and plain read-outs finish in decode.
// Product accumulate runs four 32x32 partial products, then rounding.
// Variance accumulate runs the radix-4 divider, then the multiplier and rounding;
// mean/variance read-out runs the divider, and standard deviation read-out adds a root.
// Reset is synchronous; the slot store comes out of reset empty through per-slot
// valid bits, so no clearing pass is needed. A result beat is shown for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module per_slot_running_statistics_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire psrs_pkg::t_in_item         i_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [psrs_pkg::KindW-1:0] i_cfg_data,
    output logic                            o_result_strobe,
    output psrs_pkg::t_out_item             o_result
);

    logic [psrs_pkg::KindW-1:0] r_reducer_kind;
    psrs_pkg::t_cmd  w_cmd;
    psrs_pkg::t_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reducer_kind <= psrs_pkg::KIND_MIN;
        end else if (i_cfg_we) begin
            r_reducer_kind <= i_cfg_data;
        end
    end

    psrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    psrs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_kind          (r_reducer_kind),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule
`default_nettype wire

>>> test/per_slot_running_statistics_core_tb.sv
`timescale 1ns / 1ps
module per_slot_running_statistics_core_tb;

    localparam longint CycleLimit = 3000000;
    localparam logic signed [63:0] AccMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] AccMin = 64'sh8000_0000_0000_0000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    psrs_pkg::t_in_item            i_item;
    logic                          i_cfg_we;
    logic [psrs_pkg::KindW-1:0]    i_cfg_data;
    logic                          o_result_strobe;
    psrs_pkg::t_out_item           o_result;

    per_slot_running_statistics_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    // Shadow copy of the per-slot statistics store.
    logic [psrs_pkg::KindW-1:0] stat_kind;
    logic signed [63:0] stat_acc  [psrs_pkg::TimeSlots];
    logic [31:0]        stat_cnt  [psrs_pkg::TimeSlots];
    logic signed [63:0] stat_mean [psrs_pkg::TimeSlots];
    logic               stat_sat  [psrs_pkg::TimeSlots];
    logic               sat_hit;

    psrs_pkg::t_in_item  sample_queue[$];
    psrs_pkg::t_out_item pending_results[$];
    int        gap_left;
    bit        gaps_on;
    int        mismatches;
    longint    cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] magnitude(input logic signed [63:0] x);
        return x[63] ? -x : x;
    endfunction

    function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_hit = 1'b1;
            return s[64] ? AccMin : AccMax;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sub_clamped(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            sat_hit = 1'b1;
            return s[64] ? AccMin : AccMax;
        end
        return s[63:0];
    endfunction

    // Fixed-point product, rounded to nearest with ties away from zero.
    function automatic logic signed [63:0] mul_fixed(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic         neg;
        logic [127:0] p;
        logic [127:0] lim;
        neg = a[63] ^ b[63];
        p   = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p   = (p + (128'd1 << (psrs_pkg::FracW - 1))) >> psrs_pkg::FracW;
        lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
        if (p > lim) begin
            sat_hit = 1'b1;
            return neg ? AccMin : AccMax;
        end
        return neg ? -p[63:0] : p[63:0];
    endfunction

    function automatic logic signed [63:0] div_nearest(input logic signed [63:0] n,
                                                       input logic [63:0] d);
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        m = magnitude(n);
        q = m / d;
        r = m % d;
        if (r >= d - r) q = q + 1;
        return n[63] ? -q : q;
    endfunction

    function automatic logic signed [63:0] root_fixed(input logic [63:0] v);
        logic [127:0] x;
        logic [63:0]  r;
        logic [63:0]  c;
        x = {64'd0, v} << psrs_pkg::FracW;
        r = 64'd0;
        for (int b = 47; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x) r = c;
        end
        return r;
    endfunction

    task automatic wipe_slot(input int s);
        stat_acc[s]  = (stat_kind == psrs_pkg::KIND_PROD) ? (64'sd1 <<< psrs_pkg::FracW)
                                                          : 64'sd0;
        stat_cnt[s]  = 32'd0;
        stat_mean[s] = 64'sd0;
        stat_sat[s]  = 1'b0;
    endtask

    task automatic add_sample(input int s, input logic signed [63:0] v);
        logic [31:0]        prev;
        logic signed [63:0] delta;
        logic signed [63:0] step;
        sat_hit = 1'b0;
        prev = stat_cnt[s];
        if (prev == 32'hFFFF_FFFF) sat_hit = 1'b1;
        else stat_cnt[s] = prev + 1;
        case (stat_kind)
            psrs_pkg::KIND_MIN:  if (prev == 0 || v < stat_acc[s]) stat_acc[s] = v;
            psrs_pkg::KIND_MAX:  if (prev == 0 || v > stat_acc[s]) stat_acc[s] = v;
            psrs_pkg::KIND_MEAN, psrs_pkg::KIND_SUM: stat_acc[s] = add_clamped(stat_acc[s], v);
            psrs_pkg::KIND_PROD: stat_acc[s] = mul_fixed(stat_acc[s], v);
            psrs_pkg::KIND_VAR, psrs_pkg::KIND_SD: begin
                delta = sub_clamped(v, stat_mean[s]);
                step  = div_nearest(delta, {32'd0, stat_cnt[s]});
                stat_mean[s] = add_clamped(stat_mean[s], step);
                stat_acc[s]  = add_clamped(stat_acc[s],
                                           mul_fixed(delta, sub_clamped(v, stat_mean[s])));
            end
            default: ;
        endcase
        if (sat_hit) stat_sat[s] = 1'b1;
    endtask

    task automatic predict_statistic(input psrs_pkg::t_in_item it);
        psrs_pkg::t_out_item r;
        logic [31:0]        n;
        logic signed [63:0] a;
        if (it.mode == psrs_pkg::MODE_ACC) begin
            if (it.sample_valid) add_sample(it.slot, 64'(it.sample_value));
        end else if (it.mode == psrs_pkg::MODE_CLEAR) begin
            wipe_slot(it.slot);
        end else if (it.mode == psrs_pkg::MODE_READ) begin
            n = stat_cnt[it.slot];
            a = stat_acc[it.slot];
            r.result_slot      = it.slot;
            r.result_value     = 64'sd0;
            r.result_empty     = 1'b0;
            r.result_saturated = stat_sat[it.slot];
            case (stat_kind)
                psrs_pkg::KIND_MIN, psrs_pkg::KIND_MAX: if (n == 0) r.result_empty = 1'b1;
                                                        else r.result_value = a;
                psrs_pkg::KIND_MEAN: if (n == 0) r.result_empty = 1'b1;
                                     else r.result_value = div_nearest(a, {32'd0, n});
                psrs_pkg::KIND_SUM, psrs_pkg::KIND_PROD: r.result_value = a;
                psrs_pkg::KIND_COUNT: r.result_value = {16'd0, n, 16'd0};
                default: begin
                    if (n <= 1) begin
                        r.result_empty = 1'b1;
                    end else begin
                        r.result_value = div_nearest(a, {32'd0, n} - 64'd1);
                        if (stat_kind == psrs_pkg::KIND_SD)
                            r.result_value = root_fixed(r.result_value[63] ? 64'd0
                                                                           : r.result_value);
                    end
                end
            endcase
            pending_results = {pending_results, r};
        end
    endtask

    function automatic int pick_gap();
        if (!gaps_on || $urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: a beat is taken when start is high and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) predict_statistic(i_item);
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (sample_queue.size() > 0) begin
                start    <= 1'b1;
                i_item   <= sample_queue.pop_front();
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each strobed beat is compared with the oldest expected result.
    always @(posedge i_clk) begin
        psrs_pkg::t_out_item want;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("per_slot_running_statistics_core: mismatch");
            $finish;
        end
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result differs: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
            2: return 32'sh0001_0000 + $signed(32'($urandom_range(0, 4096))) - 32'sd2048;
            default: return ($signed(32'($urandom_range(0, 16))) - 32'sd8) * 32'sh0001_0000
                            + $signed(32'($urandom_range(0, 65535)));
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] m, input logic [7:0] s,
                              input logic signed [31:0] v, input logic ok);
        psrs_pkg::t_in_item it;
        it.mode         = m;
        it.slot         = s;
        it.sample_value = v;
        it.sample_valid = ok;
        sample_queue = {sample_queue, it};
    endtask

    task automatic wait_idle();
        while (sample_queue.size() > 0 || start || busy || pending_results.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic set_kind(input logic [psrs_pkg::KindW-1:0] k);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        stat_kind  = k;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int          roll;
        logic [7:0]  s;
        gaps_on = $urandom_range(0, 3) != 0;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            s = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
            if (roll < 65)
                queue_item(psrs_pkg::MODE_ACC, s, pick_value(), $urandom_range(0, 9) != 0);
            else if (roll < 88)
                queue_item(psrs_pkg::MODE_READ, s, $urandom, $urandom_range(0, 1));
            else if (roll < 97)
                queue_item(psrs_pkg::MODE_CLEAR, s, $urandom, $urandom_range(0, 1));
            else
                queue_item(2'd3, s, $urandom, $urandom_range(0, 1));
        end
        wait_idle();
    endtask

    initial begin
        static logic [psrs_pkg::KindW-1:0] kinds[12] = '{
            psrs_pkg::KIND_MIN, psrs_pkg::KIND_MAX, psrs_pkg::KIND_MEAN, psrs_pkg::KIND_SUM,
            psrs_pkg::KIND_COUNT, psrs_pkg::KIND_PROD, psrs_pkg::KIND_VAR, psrs_pkg::KIND_SD,
            psrs_pkg::KIND_SD, psrs_pkg::KIND_MIN, psrs_pkg::KIND_VAR, psrs_pkg::KIND_PROD};
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_item     = '0;
        start      = 1'b0;
        gap_left   = 0;
        gaps_on    = 1'b0;
        mismatches = 0;
        cycles     = 0;
        stat_kind  = psrs_pkg::KIND_MIN;
        for (int s = 0; s < psrs_pkg::TimeSlots; s++) wipe_slot(s);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty reads, field extremes, a skipped sample, unused mode, clear.
        queue_item(psrs_pkg::MODE_READ, 8'd0, 32'sd0, 1'b1);
        queue_item(psrs_pkg::MODE_READ, 8'd255, 32'sd0, 1'b0);
        queue_item(psrs_pkg::MODE_ACC, 8'd255, 32'sh7FFF_FFFF, 1'b1);
        queue_item(psrs_pkg::MODE_ACC, 8'd255, 32'sh8000_0000, 1'b1);
        queue_item(psrs_pkg::MODE_ACC, 8'd255, 32'sh8000_0000, 1'b0);
        queue_item(psrs_pkg::MODE_READ, 8'd255, 32'sd0, 1'b1);
        queue_item(2'd3, 8'd255, 32'shFFFF_FFFF, 1'b1);
        queue_item(psrs_pkg::MODE_CLEAR, 8'd255, 32'sd0, 1'b1);
        queue_item(psrs_pkg::MODE_READ, 8'd255, 32'sd0, 1'b1);
        queue_item(psrs_pkg::MODE_ACC, 8'd1, 32'sh0002_0000, 1'b1);
        queue_item(psrs_pkg::MODE_ACC, 8'd1, 32'sh0006_0000, 1'b1);
        wait_idle();

        // Every kind reads the same slot without a clear in between.
        for (int k = 0; k < 8; k++) begin
            set_kind(k[psrs_pkg::KindW-1:0]);
            queue_item(psrs_pkg::MODE_READ, 8'd1, 32'sd0, 1'b1);
            queue_item(psrs_pkg::MODE_ACC, 8'd1, 32'sh7FFF_FFFF, 1'b1);
            wait_idle();
        end

        for (int p = 0; p < 12; p++) begin
            set_kind(kinds[p]);
            random_phase(80);
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("per_slot_running_statistics_core: match");
        end else begin
            $display("per_slot_running_statistics_core: mismatch");
        end
        $finish;
    end

endmodule
